// ----- sv/aot_pkg.sv -----
// ---------------------------------------------------------------------------
// aot_pkg: shared types and constants for the box overlap block
// Field widths, wide arithmetic types, register map and pipeline control.
// ---------------------------------------------------------------------------
`default_nettype none

package aot_pkg;

  // Field types of one box pair and one result
  typedef logic signed [31:0] pos_t;
  typedef logic        [30:0] size_t;
  typedef logic signed [33:0] shift_t;

  // Internal width: holds doubled sums of a corner and an extent
  localparam int WIDE_W = 35;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic        [WIDE_W-1:0] mag_t;

  // Register map: register i at byte address 4*i
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  localparam cfg_idx_t REG_THREE_D   = cfg_idx_t'(0);
  localparam logic     THREE_D_RESET = 1'b1;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // Per-axis result handed to the final stage
  typedef struct packed {
    logic  ovl;
    mag_t  near_mag;
    mag_t  far_mag;
    wide_t sft_far;
    wide_t sft_near;
  } axis_res_t;

endpackage

`default_nettype wire

// ----- sv/aot_in_if.sv -----
// ---------------------------------------------------------------------------
// aot_in_if: input channel carrying one box pair
// Valid/ready handshake with the twelve corner and extent fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface aot_in_if import aot_pkg::*; ();
  logic  valid;
  logic  ready;
  pos_t  a_pos_x;
  pos_t  a_pos_y;
  pos_t  a_pos_z;
  size_t a_size_x;
  size_t a_size_y;
  size_t a_size_z;
  pos_t  b_pos_x;
  pos_t  b_pos_y;
  pos_t  b_pos_z;
  size_t b_size_x;
  size_t b_size_y;
  size_t b_size_z;

  modport source (
    output valid, a_pos_x, a_pos_y, a_pos_z, a_size_x, a_size_y, a_size_z,
           b_pos_x, b_pos_y, b_pos_z, b_size_x, b_size_y, b_size_z,
    input  ready
  );

  modport sink (
    input  valid, a_pos_x, a_pos_y, a_pos_z, a_size_x, a_size_y, a_size_z,
           b_pos_x, b_pos_y, b_pos_z, b_size_x, b_size_y, b_size_z,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/aot_out_if.sv -----
// ---------------------------------------------------------------------------
// aot_out_if: result channel
// Valid/ready handshake with the hit flag and three translation distances.
// ---------------------------------------------------------------------------
`default_nettype none

interface aot_out_if import aot_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  shift_t shift_x;
  shift_t shift_y;
  shift_t shift_z;

  modport source (output valid, hit, shift_x, shift_y, shift_z, input ready);
  modport sink   (input  valid, hit, shift_x, shift_y, shift_z, output ready);
endinterface

`default_nettype wire

// ----- sv/aot_pipe_ctrl.sv -----
// ---------------------------------------------------------------------------
// aot_pipe_ctrl: valid bits and stall control of the four-stage pipeline
// Each stage loads when it is empty or its successor loads, so bubbles
// collapse and a stalled result never blocks the empty stages behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module aot_pipe_ctrl import aot_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  output logic          out_valid,
  output pipe_en_t      en
);

  logic v1_r, v2_r, v3_r, v4_r;

  // Ready chain from the output back to the input
  always_comb begin
    en.s4 = !v4_r || out_ready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_ready  = en.s1;
  assign out_valid = v4_r;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

endmodule

`default_nettype wire

// ----- sv/aot_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// aot_cfg_regs: APB-style configuration register
// Holds the three-dimensional mode bit; pready is tied high.
// ---------------------------------------------------------------------------
`default_nettype none

module aot_cfg_regs import aot_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire cfg_addr_t   paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic             three_d
);

  logic     three_d_r;
  logic     three_d_nxt;
  cfg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_THREE_D);

  // Update the mode bit on a completed write transaction
  always_comb begin
    three_d_nxt = three_d_r;
    if (wr_en) begin
      three_d_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      three_d_r <= THREE_D_RESET;
    end else begin
      three_d_r <= three_d_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_THREE_D) begin
      prdata = {31'd0, three_d_r};
    end
  end

  assign three_d = three_d_r;

endmodule

`default_nettype wire

// ----- sv/aot_axis_pipe.sv -----
// ---------------------------------------------------------------------------
// aot_axis_pipe: three stages of the per-axis overlap and shift datapath
// Stage 1 forms the box ends and the doubled center, stage 2 the overlap
// flag, doubled end-to-center distances and both shift candidates, stage 3
// the magnitudes of the two distances.
// ---------------------------------------------------------------------------
`default_nettype none

module aot_axis_pipe import aot_pkg::*; (
  input  wire logic      clk,
  input  wire pipe_en_t  en,
  input  wire pos_t      pa,
  input  wire size_t     da,
  input  wire pos_t      pb,
  input  wire size_t     db,
  output axis_res_t      res
);

  wide_t pa_w, pb_w, da_w, db_w;

  // Stage 1 registers
  wide_t pa_r, pb_r, ea_r, eb_r, pa2_r, c2_r;
  // Stage 2 registers
  logic  ovl2_r;
  wide_t near2_r, far2_r, sft_far2_r, sft_near2_r;
  // Stage 3 registers
  axis_res_t res_r;

  // Extend to the internal width
  assign pa_w = {{(WIDE_W-32){pa[31]}}, pa};
  assign pb_w = {{(WIDE_W-32){pb[31]}}, pb};
  assign da_w = {{(WIDE_W-31){1'b0}}, da};
  assign db_w = {{(WIDE_W-31){1'b0}}, db};

  // Stage 1: box ends, doubled corner of A, doubled center of B
  always_ff @(posedge clk) begin
    if (en.s1) begin
      pa_r  <= pa_w;
      pb_r  <= pb_w;
      ea_r  <= pa_w + da_w;
      eb_r  <= pb_w + db_w;
      pa2_r <= pa_w + pa_w;
      c2_r  <= pb_w + pb_w + db_w;
    end
  end

  // Stage 2: overlap along this axis, distances, shift candidates
  always_ff @(posedge clk) begin
    if (en.s2) begin
      ovl2_r      <= ((pa_r <= pb_r) && (ea_r > pb_r)) ||
                     ((pb_r <= pa_r) && (eb_r > pa_r));
      near2_r     <= pa2_r - c2_r;
      far2_r      <= ea_r + ea_r - c2_r;
      sft_far2_r  <= eb_r - pa_r;
      sft_near2_r <= pb_r - ea_r;
    end
  end

  // Stage 3: magnitudes of the two distances
  always_ff @(posedge clk) begin
    if (en.s3) begin
      res_r.ovl      <= ovl2_r;
      res_r.near_mag <= near2_r[WIDE_W-1] ? mag_t'(-near2_r) : mag_t'(near2_r);
      res_r.far_mag  <= far2_r[WIDE_W-1] ? mag_t'(-far2_r) : mag_t'(far2_r);
      res_r.sft_far  <= sft_far2_r;
      res_r.sft_near <= sft_near2_r;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- sv/aabb_overlap_and_translation.sv -----
// ---------------------------------------------------------------------------
// aabb_overlap_and_translation: box overlap test with translation distances
// Top level: config register, pipeline control, three axis datapaths and
// the output stage that picks each shift and combines the hit flag.
// ---------------------------------------------------------------------------
// The block takes one box pair per clock when the output is not stalled
// and returns one result per pair, in order. Each pair passes through the
// four register stages of the axis datapath and the output stage. When
// the result side stalls, the stages behind the waiting result keep
// filling, and input ready drops only once all four stages hold a pair.
// The mode bit at address 0 (reset 1) selects three-dimensional testing;
// with it cleared the z fields have no effect and shift_z is zero. Write
// the mode only while the pipeline is empty.
`default_nettype none

module aabb_overlap_and_translation import aot_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  aot_in_if.sink           in_bus,
  aot_out_if.source        out_bus,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire cfg_addr_t   cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  pipe_en_t  en;
  logic      three_d;
  axis_res_t res_x, res_y, res_z;

  logic   hit_r;
  shift_t shift_x_r, shift_y_r, shift_z_r;

  aot_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .three_d (three_d)
  );

  aot_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .en        (en)
  );

  aot_axis_pipe u_axis_x (
    .clk (clk), .en (en),
    .pa  (in_bus.a_pos_x), .da (in_bus.a_size_x),
    .pb  (in_bus.b_pos_x), .db (in_bus.b_size_x),
    .res (res_x)
  );

  aot_axis_pipe u_axis_y (
    .clk (clk), .en (en),
    .pa  (in_bus.a_pos_y), .da (in_bus.a_size_y),
    .pb  (in_bus.b_pos_y), .db (in_bus.b_size_y),
    .res (res_y)
  );

  aot_axis_pipe u_axis_z (
    .clk (clk), .en (en),
    .pa  (in_bus.a_pos_z), .da (in_bus.a_size_z),
    .pb  (in_bus.b_pos_z), .db (in_bus.b_size_z),
    .res (res_z)
  );

  // Pick the shift: far end of B when A's near end is farther from B's center
  function automatic shift_t pick_shift(input axis_res_t r);
    wide_t s;
    s = (r.near_mag > r.far_mag) ? r.sft_far : r.sft_near;
    return shift_t'(s);
  endfunction

  // Output stage: hold while stalled, load when the result moves on
  always_ff @(posedge clk) begin
    if (en.s4) begin
      hit_r     <= res_x.ovl && res_y.ovl && (res_z.ovl || !three_d);
      shift_x_r <= pick_shift(res_x);
      shift_y_r <= pick_shift(res_y);
      shift_z_r <= three_d ? pick_shift(res_z) : '0;
    end
  end

  assign out_bus.hit     = hit_r;
  assign out_bus.shift_x = shift_x_r;
  assign out_bus.shift_y = shift_y_r;
  assign out_bus.shift_z = shift_z_r;

endmodule

`default_nettype wire

// ----- sv/aot_checker.sv -----
// ---------------------------------------------------------------------------
// aot_checker: port-level checks of the box overlap block
// Reset, ready behavior, result hold under stall and two-dimensional mode.
// ---------------------------------------------------------------------------
`default_nettype none

module aot_checker import aot_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire shift_t      out_shift_x,
  input wire shift_t      out_shift_y,
  input wire shift_t      out_shift_z,
  input wire cfg_addr_t   cfg_paddr,
  input wire logic [31:0] cfg_prdata
);

  // Drop all results at reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Keep accepting while the output stage is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_shift_x) && $stable(out_shift_y) && $stable(out_shift_z))
    else $error("stalled result changed");

  // Zero z shift in two-dimensional mode
  a_two_d_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cfg_paddr[CFG_ADDR_W-1:2] == REG_THREE_D) && !cfg_prdata[0]
      |-> out_shift_z == '0)
    else $error("nonzero z shift in two-dimensional mode");

endmodule

bind aabb_overlap_and_translation aot_checker u_aot_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_hit     (out_bus.hit),
  .out_shift_x (out_bus.shift_x),
  .out_shift_y (out_bus.shift_y),
  .out_shift_z (out_bus.shift_z),
  .cfg_paddr   (cfg_paddr),
  .cfg_prdata  (cfg_prdata)
);

`default_nettype wire
